// ----- rtl/core/gcd_pkg.sv -----
package gcd_pkg;

   // default parameter values
   localparam int ANGLE_FRACTION_BITS_DEF = 20;
   localparam int CORDIC_STAGES_DEF       = 24;

   // field widths
   localparam int LAT_W    = 28;
   localparam int LON_W    = 29;
   localparam int RADIUS_W = 24;
   localparam int DIST_W   = 26;

   // datapath widths
   localparam int WORD_W   = 34;   // angles, cordic x/y/z, degree arithmetic
   localparam int MAG_W    = 31;   // degree magnitude, acos argument magnitude
   localparam int Q_W      = 32;   // sine/cosine handed to the multipliers
   localparam int SQ_W     = 62;   // square root remainder and root
   localparam int SQ_STEPS = 31;   // one root bit per step

   // Q30 constants
   localparam logic [31:0] GAIN_INV = 32'h26DD3B6A;
   localparam logic [31:0] QPI      = 32'h3243F6A8;
   localparam logic signed [WORD_W-1:0] PI_Q30 = WORD_W'(64'd4 * 64'(QPI));
   localparam logic signed [WORD_W-1:0] ONE_Q30 = WORD_W'(64'd1 << 30);

   // floor(2^37 / 45), reciprocal for the degree to radian divide
   localparam logic [31:0] RECIP_45 = 32'hB60B60B6;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;

   // arctangent of 2^-i in Q30
   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   // sideband that travels with each item down the pipeline
   typedef struct packed {
      logic             rep;
      logic             flip;
      logic             sat;
      logic             neg;
      logic [MAG_W-1:0] mag;
   } side_type;

endpackage

// ----- rtl/core/gcd_deg2rad.sv -----
module gcd_deg2rad #(
   parameter int ANGLE_FRACTION_BITS = gcd_pkg::ANGLE_FRACTION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic [gcd_pkg::MAG_W-1:0]           mag,
   input  logic                                neg,
   output logic signed [gcd_pkg::WORD_W-1:0]   rad
);
   import gcd_pkg::*;

   localparam int P_W = MAG_W + 30;
   localparam int T_W = 37;
   localparam logic [P_W-1:0] HALF_DEN = P_W'(45) << (ANGLE_FRACTION_BITS - 1);

   logic [P_W-1:0]  p_ff, p_in;
   logic [T_W-1:0]  t_ff, t_in;
   logic [T_W-1:0]  t3_ff;
   logic [63:0]     prod_ff, prod_in;
   logic [31:0]     q0_ff, q0_in;
   logic [7:0]      r_ff, r_in;
   logic [4:1]      neg_ff;
   logic signed [WORD_W-1:0] rad_ff, rad_in;
   logic [P_W-1:0]  sum;
   logic [T_W-1:0]  back;
   logic [31:0]     q;

   // scale by pi/4, round, then divide by 45 through a reciprocal with a fix-up
   always_comb begin
      p_in    = P_W'(mag) * P_W'(QPI);
      sum     = p_ff + HALF_DEN;
      t_in    = T_W'(sum >> ANGLE_FRACTION_BITS);
      prod_in = {32'b0, t_ff[T_W-1:5]} * {32'b0, RECIP_45};
      q0_in   = prod_ff[63:32];
      back    = t3_ff - T_W'(q0_in) * T_W'(45);
      r_in    = back[7:0];
      if (r_ff >= 8'd90) begin
         q = q0_ff + 32'd2;
      end else if (r_ff >= 8'd45) begin
         q = q0_ff + 32'd1;
      end else begin
         q = q0_ff;
      end
      rad_in = neg_ff[4] ? -WORD_W'(q) : WORD_W'(q);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff    <= p_in;
         t_ff    <= t_in;
         prod_ff <= prod_in;
         t3_ff   <= t_ff;
         q0_ff   <= q0_in;
         r_ff    <= r_in;
         rad_ff  <= rad_in;
         neg_ff  <= {neg_ff[3:1], neg};
      end
   end

   assign rad = rad_ff;

endmodule

// ----- rtl/core/gcd_cordic_cell.sv -----
module gcd_cordic_cell #(
   parameter int IDX    = 0,
   parameter bit VECTOR = 1'b0
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [gcd_pkg::WORD_W-1:0] src_x,
   input  logic signed [gcd_pkg::WORD_W-1:0] src_y,
   input  logic signed [gcd_pkg::WORD_W-1:0] src_z,
   output logic signed [gcd_pkg::WORD_W-1:0] dst_x,
   output logic signed [gcd_pkg::WORD_W-1:0] dst_y,
   output logic signed [gcd_pkg::WORD_W-1:0] dst_z
);
   import gcd_pkg::*;

   localparam logic signed [WORD_W-1:0] STEP = WORD_W'(ATAN_TAB[IDX]);

   logic signed [WORD_W-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic turn_pos;

   // rotation steers by the residual angle, vectoring by the sign of y
   always_comb begin
      turn_pos = VECTOR ? src_y[WORD_W-1] : !src_z[WORD_W-1];
      if (turn_pos) begin
         x_in = src_x - (src_y >>> IDX);
         y_in = src_y + (src_x >>> IDX);
         z_in = src_z - STEP;
      end else begin
         x_in = src_x + (src_y >>> IDX);
         y_in = src_y - (src_x >>> IDX);
         z_in = src_z + STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign dst_x = x_ff;
   assign dst_y = y_ff;
   assign dst_z = z_ff;

endmodule

// ----- rtl/core/gcd_isqrt_cell.sv -----
module gcd_isqrt_cell #(
   parameter int IDX = 0
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [gcd_pkg::SQ_W-1:0]   src_u,
   input  logic [gcd_pkg::SQ_W-1:0]   src_r,
   output logic [gcd_pkg::SQ_W-1:0]   dst_u,
   output logic [gcd_pkg::SQ_W-1:0]   dst_r
);
   import gcd_pkg::*;

   localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (60 - 2 * IDX);

   logic [SQ_W-1:0] u_ff, r_ff, u_in, r_in, trial;

   // one root bit: subtract the trial square when it fits
   always_comb begin
      trial = src_r + BIT;
      if (src_u >= trial) begin
         u_in = src_u - trial;
         r_in = (src_r >> 1) + BIT;
      end else begin
         u_in = src_u;
         r_in = src_r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff <= u_in;
         r_ff <= r_in;
      end
   end

   assign dst_u = u_ff;
   assign dst_r = r_ff;

endmodule

// ----- rtl/core/great_circle_distance.sv -----
// channel  direction  handshake              payload
// req      in         req_tvalid/req_tready  req_tdata: two points (lat, lon, lat, lon)
// rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: distance, rsp_tuser: flags
// csr      in         csr_wr_en              csr_wr_data: sphere radius
//
// One item enters per cycle while the skid register is empty; each passes from accept to result
// through the cell chains: three parallel rotation chains, the 31-step square root chain
// and the vectoring chain.
// Reset clears the pipeline valid bits and the output and skid valid flags and sets the
// radius to 6371000.
// A stalled result moves into a skid register; the pipeline halts only while that is full.
module great_circle_distance #(
   parameter int ANGLE_FRACTION_BITS = gcd_pkg::ANGLE_FRACTION_BITS_DEF,
   parameter int CORDIC_STAGES       = gcd_pkg::CORDIC_STAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [119:0]                      req_tdata,  // first_lat, first_lon, second_lat, second_lon
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // distance
   output logic [1:0]                        rsp_tuser,  // coord_replaced, cos_saturated
   input  logic                              csr_wr_en,
   input  logic [gcd_pkg::RADIUS_W-1:0]      csr_wr_data
);
   import gcd_pkg::*;

   localparam int CS       = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int I_A      = 0;
   localparam int I_B      = I_A + 1;
   localparam int I_C      = I_B + 1;
   localparam int I_RAD    = I_C + 5;
   localparam int I_ROT    = I_RAD + CS;
   localparam int I_P1     = I_ROT + 1;
   localparam int I_P2     = I_P1 + 1;
   localparam int I_P3     = I_P2 + 1;
   localparam int I_P4     = I_P3 + 1;
   localparam int I_SQ     = I_P4 + SQ_STEPS;
   localparam int I_VEC    = I_SQ + CS;
   localparam int I_V1     = I_VEC + 1;
   localparam int I_V2     = I_V1 + 1;
   localparam int PIPE_LEN = I_V2 + 1;

   localparam logic signed [WORD_W-1:0] QUARTER = WORD_W'(90) << ANGLE_FRACTION_BITS;
   localparam logic signed [WORD_W-1:0] HALF    = WORD_W'(180) << ANGLE_FRACTION_BITS;
   localparam logic signed [WORD_W-1:0] FULL    = WORD_W'(360) << ANGLE_FRACTION_BITS;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              rep;
      logic              sat;
   } out_type;

   logic adv;

   // radius register
   logic [RADIUS_W-1:0] radius_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   // valid bits and sideband
   logic     valid_ff [PIPE_LEN];
   logic     valid_in [PIPE_LEN];
   side_type side_ff  [PIPE_LEN];
   side_type side_in  [PIPE_LEN];

   // stage A: range check
   logic signed [WORD_W-1:0] f_la1, f_lo1, f_la2, f_lo2;
   logic bad_la1, bad_lo1, bad_la2, bad_lo2;
   logic signed [WORD_W-1:0] a_la1_ff, a_lo1_ff, a_la2_ff, a_lo2_ff;
   logic signed [WORD_W-1:0] a_la1_in, a_lo1_in, a_la2_in, a_lo2_in;

   always_comb begin
      f_la1   = WORD_W'(signed'(req_tdata[27:0]));
      f_lo1   = WORD_W'(signed'(req_tdata[56:28]));
      f_la2   = WORD_W'(signed'(req_tdata[84:57]));
      f_lo2   = WORD_W'(signed'(req_tdata[113:85]));
      bad_la1 = (f_la1 > QUARTER) || (f_la1 < -QUARTER);
      bad_lo1 = (f_lo1 > HALF) || (f_lo1 < -HALF);
      bad_la2 = (f_la2 > QUARTER) || (f_la2 < -QUARTER);
      bad_lo2 = (f_lo2 > HALF) || (f_lo2 < -HALF);
      a_la1_in = bad_la1 ? '0 : f_la1;
      a_lo1_in = bad_lo1 ? '0 : f_lo1;
      a_la2_in = bad_la2 ? '0 : f_la2;
      a_lo2_in = bad_lo2 ? '0 : f_lo2;
   end

   // stage B: longitude difference magnitude
   logic signed [WORD_W-1:0] b_la1_ff, b_la2_ff, b_dl_ff, b_dl_in, dl_raw;
   always_comb begin
      dl_raw  = a_lo2_ff - a_lo1_ff;
      b_dl_in = dl_raw[WORD_W-1] ? -dl_raw : dl_raw;
   end

   // stage C: fold the difference into a quarter turn, split latitudes into sign and size
   logic signed [WORD_W-1:0] dl_wrap, dl_fold, la1_abs, la2_abs;
   logic                     flip_c;
   logic [MAG_W-1:0] c_mla1_ff, c_mla2_ff, c_mdl_ff;
   logic             c_nla1_ff, c_nla2_ff;
   always_comb begin
      dl_wrap = (b_dl_ff > HALF) ? FULL - b_dl_ff : b_dl_ff;
      flip_c  = dl_wrap > QUARTER;
      dl_fold = flip_c ? HALF - dl_wrap : dl_wrap;
      la1_abs = b_la1_ff[WORD_W-1] ? -b_la1_ff : b_la1_ff;
      la2_abs = b_la2_ff[WORD_W-1] ? -b_la2_ff : b_la2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_la1_ff  <= a_la1_in;
         a_lo1_ff  <= a_lo1_in;
         a_la2_ff  <= a_la2_in;
         a_lo2_ff  <= a_lo2_in;
         b_la1_ff  <= a_la1_ff;
         b_la2_ff  <= a_la2_ff;
         b_dl_ff   <= b_dl_in;
         c_mla1_ff <= la1_abs[MAG_W-1:0];
         c_nla1_ff <= b_la1_ff[WORD_W-1];
         c_mla2_ff <= la2_abs[MAG_W-1:0];
         c_nla2_ff <= b_la2_ff[WORD_W-1];
         c_mdl_ff  <= dl_fold[MAG_W-1:0];
      end
   end

   // degrees to radians, one unit per angle
   logic signed [WORD_W-1:0] rad [3];
   gcd_deg2rad #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_rad_la1 (
      .clock(clock), .en(adv), .mag(c_mla1_ff), .neg(c_nla1_ff), .rad(rad[0]));
   gcd_deg2rad #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_rad_la2 (
      .clock(clock), .en(adv), .mag(c_mla2_ff), .neg(c_nla2_ff), .rad(rad[1]));
   gcd_deg2rad #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_rad_dl (
      .clock(clock), .en(adv), .mag(c_mdl_ff), .neg(1'b0), .rad(rad[2]));

   // sine and cosine: three rotation chains
   logic signed [WORD_W-1:0] rot_x [3][CS+1];
   logic signed [WORD_W-1:0] rot_y [3][CS+1];
   logic signed [WORD_W-1:0] rot_z [3][CS+1];
   for (genvar ch = 0; ch < 3; ch++) begin : g_rot
      assign rot_x[ch][0] = WORD_W'(GAIN_INV);
      assign rot_y[ch][0] = '0;
      assign rot_z[ch][0] = rad[ch];
      for (genvar j = 0; j < CS; j++) begin : g_cell
         gcd_cordic_cell #(.IDX(j), .VECTOR(1'b0)) u_cell (
            .clock(clock), .en(adv),
            .src_x(rot_x[ch][j]), .src_y(rot_y[ch][j]), .src_z(rot_z[ch][j]),
            .dst_x(rot_x[ch][j+1]), .dst_y(rot_y[ch][j+1]), .dst_z(rot_z[ch][j+1]));
      end
   end

   // products: sin a * sin b + (cos a * cos b) * cos dlon
   logic signed [63:0]       ss_ff, ss_in, cc_ff, cc_in, ccd_ff, ccd_in;
   logic signed [Q_W-1:0]    cdf_ff, cdf_in;
   logic signed [WORD_W-1:0] ss30_ff, ss30_in, cos_c, cc30;
   logic signed [WORD_W-1:0] cdl_full;
   logic                     c_sat, c_neg;
   logic signed [WORD_W-1:0] c_clamp, c_abs;
   logic [SQ_W-1:0]          u_ff, u_in;

   always_comb begin
      ss_in    = 64'(signed'(rot_y[0][CS][Q_W-1:0])) * 64'(signed'(rot_y[1][CS][Q_W-1:0]));
      cc_in    = 64'(signed'(rot_x[0][CS][Q_W-1:0])) * 64'(signed'(rot_x[1][CS][Q_W-1:0]));
      cdl_full = side_ff[I_ROT].flip ? -rot_x[2][CS] : rot_x[2][CS];
      cdf_in   = cdl_full[Q_W-1:0];
      ss30_in  = WORD_W'(ss_ff >>> 30);
      cc30     = WORD_W'(cc_ff >>> 30);
      ccd_in   = 64'(signed'(cc30[Q_W-1:0])) * 64'(cdf_ff);
      cos_c    = ss30_ff + WORD_W'(ccd_ff >>> 30);
      c_sat    = (cos_c > ONE_Q30) || (cos_c < -ONE_Q30);
      if (cos_c > ONE_Q30) begin
         c_clamp = ONE_Q30;
      end else if (cos_c < -ONE_Q30) begin
         c_clamp = -ONE_Q30;
      end else begin
         c_clamp = cos_c;
      end
      c_neg = c_clamp[WORD_W-1];
      c_abs = c_neg ? -c_clamp : c_clamp;
      u_in  = (SQ_W'(1) << 60) - SQ_W'(side_ff[I_P3].mag) * SQ_W'(side_ff[I_P3].mag);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ss_ff   <= ss_in;
         cc_ff   <= cc_in;
         cdf_ff  <= cdf_in;
         ss30_ff <= ss30_in;
         ccd_ff  <= ccd_in;
         u_ff    <= u_in;
      end
   end

   // sqrt(1 - c^2): one root bit per cell
   logic [SQ_W-1:0] sq_u [SQ_STEPS+1];
   logic [SQ_W-1:0] sq_r [SQ_STEPS+1];
   assign sq_u[0] = u_ff;
   assign sq_r[0] = '0;
   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
      gcd_isqrt_cell #(.IDX(j)) u_cell (
         .clock(clock), .en(adv),
         .src_u(sq_u[j]), .src_r(sq_r[j]), .dst_u(sq_u[j+1]), .dst_r(sq_r[j+1]));
   end

   // arccosine as the angle of (|c|, sqrt(1 - c^2))
   logic signed [WORD_W-1:0] vec_x [CS+1];
   logic signed [WORD_W-1:0] vec_y [CS+1];
   logic signed [WORD_W-1:0] vec_z [CS+1];
   assign vec_x[0] = WORD_W'(side_ff[I_SQ].mag);
   assign vec_y[0] = WORD_W'(sq_r[SQ_STEPS]);
   assign vec_z[0] = '0;
   for (genvar j = 0; j < CS; j++) begin : g_vec
      gcd_cordic_cell #(.IDX(j), .VECTOR(1'b1)) u_cell (
         .clock(clock), .en(adv),
         .src_x(vec_x[j]), .src_y(vec_y[j]), .src_z(vec_z[j]),
         .dst_x(vec_x[j+1]), .dst_y(vec_y[j+1]), .dst_z(vec_z[j+1]));
   end

   // mirror for negative c, clamp to [0, pi], scale by the radius
   logic signed [WORD_W-1:0] ang_raw;
   logic [31:0]              ang_ff, ang_in;
   logic [55:0]              dprod_ff, dprod_in;
   always_comb begin
      ang_raw = side_ff[I_VEC].neg ? PI_Q30 - vec_z[CS] : vec_z[CS];
      if (ang_raw[WORD_W-1]) begin
         ang_in = '0;
      end else if (ang_raw > PI_Q30) begin
         ang_in = PI_Q30[31:0];
      end else begin
         ang_in = ang_raw[31:0];
      end
      dprod_in = 56'(radius_ff) * 56'(ang_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff   <= ang_in;
         dprod_ff <= dprod_in;
      end
   end

   // valid and sideband shift
   always_comb begin
      valid_in[0]    = req_tvalid;
      side_in[0]     = '0;
      side_in[0].rep = bad_la1 || bad_lo1 || bad_la2 || bad_lo2;
      for (int k = 1; k < PIPE_LEN; k++) begin
         valid_in[k] = valid_ff[k-1];
         side_in[k]  = side_ff[k-1];
      end
      side_in[I_C].flip = flip_c;
      side_in[I_P3].sat = c_sat;
      side_in[I_P3].neg = c_neg;
      side_in[I_P3].mag = c_abs[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_LEN; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         for (int k = 0; k < PIPE_LEN; k++) begin
            valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < PIPE_LEN; k++) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   // rounding to whole radius units
   logic [56:0] dround;
   out_type     pipe_out;
   always_comb begin
      dround            = 57'(dprod_ff) + (57'(1) << 29);
      pipe_out.distance = dround[55:30];
      pipe_out.rep      = side_ff[I_V2].rep;
      pipe_out.sat      = side_ff[I_V2].sat;
   end

   // output register with skid
   logic    rsp_valid_ff, skid_valid_ff, rsp_valid_in, skid_valid_in;
   out_type rsp_ff, skid_ff, rsp_in, skid_in;
   logic    pipe_valid, out_free;

   assign pipe_valid = valid_ff[I_V2];
   assign adv        = !skid_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_free) begin
         rsp_valid_in = pipe_valid;
         rsp_in       = pipe_out;
      end else if (pipe_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = pipe_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32 - DIST_W){1'b0}}, rsp_ff.distance};
   assign rsp_tuser  = {rsp_ff.sat, rsp_ff.rep};

   // skid only ever holds an item behind a waiting output
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds an item while the output register is empty");

   // a finished item meeting a blocked output lands in the skid register
   a_skid_catch : assert property (@(posedge clock) disable iff (reset)
      (pipe_valid && adv && rsp_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("finished item dropped while output stalled");

   // distance never exceeds pi times the largest radius
   a_dist_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.distance <= 26'd52707280))
      else $error("distance out of range");

endmodule

// ----- verif/tb_great_circle_distance.sv -----
`timescale 1ns / 100ps

module tb_great_circle_distance;
   import gcd_pkg::*;

   localparam longint DEG    = longint'(1) << ANGLE_FRACTION_BITS_DEF;
   localparam int     STAGES = (CORDIC_STAGES_DEF > 32) ? 32 : CORDIC_STAGES_DEF;
   localparam int     SETTLE = 2 * CORDIC_STAGES_DEF + 60;

   // one pair of points as it travels on req_tdata
   typedef struct packed {
      logic signed [LON_W-1:0] lon_b;
      logic signed [LAT_W-1:0] lat_b;
      logic signed [LON_W-1:0] lon_a;
      logic signed [LAT_W-1:0] lat_a;
   } point_pair_type;

   // predicted distance item, with an optional hand-typed replace flag
   typedef struct {
      logic [DIST_W-1:0] distance;
      logic              rep;
      logic              sat;
      logic              pin_rep;
      logic              want_rep;
   } result_item_type;

   // directed row
   typedef struct {
      longint la1, lo1, la2, lo2;
      bit     pin_rep;
      bit     want_rep;
   } pair_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [119:0]        req_tdata = '0;  // first_lat, first_lon, second_lat, second_lon
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [31:0]         rsp_tdata;       // distance
   logic [1:0]          rsp_tuser;       // coord_replaced, cos_saturated
   logic                csr_wr_en = 1'b0;
   logic [RADIUS_W-1:0] csr_wr_data = '0;
   logic [1:0]          req_note = '0;   // pin_rep, want_rep of the item on the bus

   result_item_type     result_queue[$];
   logic [RADIUS_W-1:0] radius_shadow;
   int                errors = 0;
   int                burst_left = 0;

   great_circle_distance i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // rotation cordic: cosine and sine of a q30 angle
   function automatic void rotate_sin_cos(input longint z, output longint c, output longint s);
      longint x, y, xs, ys;
      x = longint'(GAIN_INV);
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
         end else begin
            x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
         end
      end
      c = x;
      s = y;
   endfunction

   // vectoring cordic: angle of (x, y)
   function automatic longint vector_angle(input longint x, input longint y);
      longint z, xs, ys;
      z = 0;
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
         end else begin
            x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
         end
      end
      return z;
   endfunction

   function automatic longint deg_to_q30(input longint d);
      longint unsigned m, den, q;
      m   = (d < 0) ? longint'(-d) : longint'(d);
      den = longint'(45) << ANGLE_FRACTION_BITS_DEF;
      q   = (m * longint'(QPI) + den / 2) / den;
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned u);
      longint unsigned r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > u) b >>= 2;
      while (b != 0) begin
         if (u >= r + b) begin
            u -= r + b; r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic result_item_type predict_distance(input point_pair_type p,
                                                        input logic [RADIUS_W-1:0] radius);
      result_item_type e;
      longint          la1, lo1, la2, lo2, d, ca, sa, cb, sb, cd, sd, c, ang, pi;
      longint unsigned mag, s, dist_full;
      bit              flip;
      longint quarter = 90 * DEG;
      longint half    = 180 * DEG;
      e = '{default: 0};
      flip = 0;
      la1 = p.lat_a; lo1 = p.lon_a; la2 = p.lat_b; lo2 = p.lon_b;
      // out-of-range coordinates become zero
      if (la1 < -quarter || la1 > quarter) begin la1 = 0; e.rep = 1; end
      if (lo1 < -half || lo1 > half) begin lo1 = 0; e.rep = 1; end
      if (la2 < -quarter || la2 > quarter) begin la2 = 0; e.rep = 1; end
      if (lo2 < -half || lo2 > half) begin lo2 = 0; e.rep = 1; end
      // fold the longitude difference into 0..90 degrees
      d = lo2 - lo1;
      if (d < 0) d = -d;
      if (d > half) d = 2 * half - d;
      if (d > quarter) begin d = half - d; flip = 1; end
      rotate_sin_cos(deg_to_q30(la1), ca, sa);
      rotate_sin_cos(deg_to_q30(la2), cb, sb);
      rotate_sin_cos(deg_to_q30(d), cd, sd);
      if (flip) cd = -cd;
      c = ((sa * sb) >>> 30) + ((((ca * cb) >>> 30) * cd) >>> 30);
      if (c > (longint'(1) << 30)) begin c = longint'(1) << 30; e.sat = 1; end
      if (c < -(longint'(1) << 30)) begin c = -(longint'(1) << 30); e.sat = 1; end
      mag = (c < 0) ? longint'(-c) : longint'(c);
      s   = root_floor((longint'(1) << 60) - mag * mag);
      ang = vector_angle(longint'(mag), longint'(s));
      pi  = 4 * longint'(QPI);
      if (c < 0) ang = pi - ang;
      if (ang < 0) ang = 0;
      if (ang > pi) ang = pi;
      dist_full = (longint'(radius) * longint'(ang) + (longint'(1) << 29)) >> 30;
      e.distance = dist_full[DIST_W-1:0];
      return e;
   endfunction

   // model side: predict on each accepted item, check each accepted result
   always @(posedge clock) begin
      result_item_type e;
      if (reset) radius_shadow = RADIUS_RESET;
      else begin
         if (csr_wr_en) radius_shadow = csr_wr_data;
         if (req_tvalid && req_tready) begin
            e = predict_distance(point_pair_type'(req_tdata[113:0]), radius_shadow);
            e.pin_rep  = req_note[1];
            e.want_rep = req_note[0];
            result_queue.push_back(e);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (result_queue.size() == 0) begin
               if (errors < 10) $display("unexpected item: dist %0d", rsp_tdata[DIST_W-1:0]);
               errors++;
            end else begin
               e = result_queue.pop_front();
               if (rsp_tdata[DIST_W-1:0] !== e.distance || rsp_tuser[0] !== e.rep ||
                   rsp_tuser[1] !== e.sat || (e.pin_rep && rsp_tuser[0] !== e.want_rep)) begin
                  if (errors < 10)
                     $display("mismatch: dist %0d/%0d rep %b/%b sat %b/%b (exp/got)",
                              e.distance, rsp_tdata[DIST_W-1:0], e.rep, rsp_tuser[0],
                              e.sat, rsp_tuser[1]);
                  errors++;
               end
            end
         end
      end
   end

   // receiver stalls in runs of changing style
   int rx_mode = 0;
   int rx_left = 0;
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 2);
         rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 15) == 0);
         end
      endcase
   end

   task automatic send_pair(input longint la1, lo1, la2, lo2, input bit pin, input bit want);
      point_pair_type p;
      // bursts with random gaps between them
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      p.lat_a = LAT_W'(la1);
      p.lon_a = LON_W'(lo1);
      p.lat_b = LAT_W'(la2);
      p.lon_b = LON_W'(lo2);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, p};
      req_note   <= {pin, want};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random_pair();
      longint la1, lo1, la2, lo2;
      int     kind;
      kind = $urandom_range(0, 99);
      la1 = longint'($urandom_range(0, 180 * DEG)) - 90 * DEG;
      lo1 = longint'($urandom_range(0, 360 * DEG)) - 180 * DEG;
      la2 = longint'($urandom_range(0, 180 * DEG)) - 90 * DEG;
      lo2 = longint'($urandom_range(0, 360 * DEG)) - 180 * DEG;
      if (kind >= 75 && kind < 88) begin
         // near antipodal pairs push the acos argument to its limit
         la2 = -la1 + longint'($urandom_range(0, 4)) - 2;
         lo2 = (lo1 > 0) ? lo1 - 180 * DEG : lo1 + 180 * DEG;
         lo2 += longint'($urandom_range(0, 4)) - 2;
      end else if (kind >= 88 && kind < 93) begin
         // coincident or nearly coincident points
         la2 = la1 + longint'($urandom_range(0, 2)) - 1;
         lo2 = lo1;
      end else if (kind >= 93) begin
         // raw field bits, mostly out of range
         la1 = $signed(LAT_W'($urandom()));
         lo1 = $signed(LON_W'($urandom()));
         la2 = $signed(LAT_W'($urandom()));
         lo2 = $signed(LON_W'($urandom()));
      end
      send_pair(la1, lo1, la2, lo2, 1'b0, 1'b0);
   endtask

   task automatic drain_and_write(input logic [RADIUS_W-1:0] radius);
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (result_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= radius;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // stimulus
   initial begin
      pair_row_type rows[21];
      logic [RADIUS_W-1:0] radii[4];
      rows = '{
         '{0, 0, 0, 0, 1, 0},
         '{90 * DEG, 0, -90 * DEG, 0, 1, 0},
         '{90 * DEG, 180 * DEG, 90 * DEG, -180 * DEG, 1, 0},
         '{0, -180 * DEG, 0, 180 * DEG, 1, 0},
         '{0, 0, 0, 180 * DEG, 1, 0},
         '{0, 0, 0, 90 * DEG, 1, 0},
         '{0, 0, 0, 100 * DEG, 1, 0},
         '{0, -170 * DEG, 0, 170 * DEG, 1, 0},
         '{45 * DEG, 10 * DEG, 45 * DEG, 10 * DEG, 1, 0},
         '{-45 * DEG, -100 * DEG, 30 * DEG, 120 * DEG, 1, 0},
         '{12 * DEG, 34 * DEG, -12 * DEG, -146 * DEG, 1, 0},
         '{1, 1, -1, -1, 1, 0},
         '{0, 0, 0, 1, 1, 0},
         '{90 * DEG + 1, 0, 0, 0, 1, 1},
         '{0, 0, -90 * DEG - 1, 0, 1, 1},
         '{0, 180 * DEG + 1, 0, 0, 1, 1},
         '{0, 0, 0, -180 * DEG - 1, 1, 1},
         '{134217727, 268435455, 134217727, 268435455, 1, 1},
         '{-134217728, -268435456, -134217728, -268435456, 1, 1},
         '{10 * DEG, 20 * DEG, -30 * DEG, 268435455, 1, 1},
         '{-90 * DEG, -180 * DEG, 90 * DEG, 180 * DEG, 1, 0}
      };
      radii = '{24'd1, 24'hFFFFFF, 24'd1000, RADIUS_W'($urandom_range(1, 24'hFFFFFF))};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset radius: directed rows then random
      foreach (rows[i])
         send_pair(rows[i].la1, rows[i].lo1, rows[i].la2, rows[i].lo2,
                   rows[i].pin_rep, rows[i].want_rep);
      repeat (300) send_random_pair();
      foreach (radii[r]) begin
         drain_and_write(radii[r]);
         if (r == 0)
            foreach (rows[i])
               send_pair(rows[i].la1, rows[i].lo1, rows[i].la2, rows[i].lo2,
                         rows[i].pin_rep, rows[i].want_rep);
         repeat (300) send_random_pair();
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (result_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) $display("tb_great_circle_distance: clean");
      else $display("tb_great_circle_distance: errors");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("tb_great_circle_distance: errors");
      $finish;
   end

endmodule
